[sv/sfdm_pkg.sv]
// shared types, codes and default sizes for the sample fifo with discontinuity marks
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sfdm_pkg;

  localparam int SAMPLE_DEPTH_DEF = 1024;
  localparam int MARK_DEPTH_DEF   = 32;
  localparam int MAX_READ_DEF     = 64;

  localparam int CMD_W   = 2;
  localparam int WORD_W  = 32;
  localparam int FRAME_W = 64;
  localparam int COUNT_W = 7;
  localparam int POS_W   = 32;
  localparam int STAT_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_DRAIN = 2'd3
  } cmd_t;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [FRAME_W-1:0] frame;
  } mark_t;

  typedef struct packed {
    logic [POS_W-1:0] diff;
    logic             behind;
    logic             below;
  } pos_res_t;

endpackage

`default_nettype wire

[sv/sample_fifo_with_discontinuity_marks.sv]
// Sample fifo with a side queue of discontinuity marks. Every command (write, mark,
// read, drain) is one word on the input channel; the block answers with one result
// word, or for a read with one word per returned sample, the final one flagged by
// last. Write and mark store their word or answer full, and a read that finds nothing
// readable answers empty. A drain moves the read position up to the write position,
// then drops stale marks and stops on a newer mark that is still ahead. A read pops
// each mark it has reached, checks the next pending mark when one is left, and then
// returns its samples. Every compare goes through the single shared position
// subtractor, and the sample and mark memories have registered read ports and are read
// one word at a time; a stalled output holds the block in place. Input stall is high
// from acceptance until the last result has been loaded into the output register.
// Sample store contents need no clearing after reset.
// depends on sfdm_pkg, sfdm_pos_unit, sfdm_sample_ram, sfdm_mark_ram
`timescale 1ns / 1ps
`default_nettype none

module sample_fifo_with_discontinuity_marks
  import sfdm_pkg::*;
#(
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
  parameter int MARK_DEPTH   = MARK_DEPTH_DEF,
  parameter int MAX_READ     = MAX_READ_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [CMD_W-1:0]   command,
  input  wire logic [WORD_W-1:0]  sample_in,
  input  wire logic [FRAME_W-1:0] frame_index,
  input  wire logic [COUNT_W-1:0] max_count,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [STAT_W-1:0]       status,
  output logic                    sample_valid,
  output logic [WORD_W-1:0]       sample_out,
  output logic                    discontinuity,
  output logic [FRAME_W-1:0]      start_frame,
  output logic                    last
);

  localparam int AW  = $clog2(SAMPLE_DEPTH);
  localparam int MAW = $clog2(MARK_DEPTH);
  localparam int CW  = $clog2(MARK_DEPTH + 1);
  localparam int LW  = $clog2(MAX_READ + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DSCAN,
    S_RSCAN,
    S_MREQ,
    S_MTEST,
    S_MFRAME,
    S_LIMIT,
    S_SREAD,
    S_SOUT,
    S_RESP
  } state_t;

  state_t             state;
  cmd_t               cmd;
  logic [FRAME_W-1:0] frame_l;
  logic [WORD_W-1:0]  sample_l;
  logic [LW-1:0]      want;
  logic [LW-1:0]      remaining;
  logic [POS_W-1:0]   write_total;
  logic [POS_W-1:0]   read_total;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [MAW-1:0]     mark_head;
  logic [MAW-1:0]     mark_tail;
  logic [CW-1:0]      mark_count;
  logic [STAT_W-1:0]  status_r;
  logic               disc;
  logic [FRAME_W-1:0] start;
  logic [POS_W-1:0]   mark_lag;

  logic               accept;
  logic               out_free;
  logic               out_load;
  logic [POS_W-1:0]   op_a;
  logic [POS_W-1:0]   op_b;
  logic [POS_W-1:0]   op_bound;
  pos_res_t           ures;
  logic [MAW-1:0]     tail_inc;
  logic [MAW-1:0]     head_inc;
  logic [AW-1:0]      wr_inc;
  logic [AW-1:0]      rd_inc;
  logic               s_we;
  logic               s_re;
  logic [WORD_W-1:0]  s_rdata;
  logic               m_we;
  logic               m_re;
  logic [MAW-1:0]     m_raddr;
  mark_t              m_wdata;
  mark_t              m_rdata;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free && ((state == S_SOUT) || (state == S_RESP));

  assign tail_inc = (mark_tail == MAW'(MARK_DEPTH - 1)) ? '0 : mark_tail + MAW'(1);
  assign head_inc = (mark_head == MAW'(MARK_DEPTH - 1)) ? '0 : mark_head + MAW'(1);
  assign wr_inc   = (wr_addr == AW'(SAMPLE_DEPTH - 1)) ? '0 : wr_addr + AW'(1);
  assign rd_inc   = (rd_addr == AW'(SAMPLE_DEPTH - 1)) ? '0 : rd_addr + AW'(1);

  // operand selection for the shared position unit
  always_comb begin
    op_a     = write_total;
    op_b     = read_total;
    op_bound = (cmd == CMD_READ) ? POS_W'(want) : POS_W'(SAMPLE_DEPTH);
    unique case (state)
      S_MTEST: begin
        op_a     = read_total;
        op_b     = m_rdata.pos;
        op_bound = '0;
      end
      S_LIMIT: begin
        op_a     = m_rdata.pos;
        op_b     = read_total;
        op_bound = POS_W'(remaining);
      end
      default: ;
    endcase
  end

  sfdm_pos_unit u_pos (
    .a     (op_a),
    .b     (op_b),
    .bound (op_bound),
    .res   (ures)
  );

  assign s_we = (state == S_CHECK) && (cmd == CMD_WRITE) && ures.below;
  assign s_re = (state == S_SREAD);

  sfdm_sample_ram #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_sram (
    .clk   (clk),
    .we    (s_we),
    .waddr (wr_addr),
    .wdata (sample_l),
    .re    (s_re),
    .raddr (rd_addr),
    .rdata (s_rdata)
  );

  assign m_we          = (state == S_CHECK) && (cmd == CMD_MARK) &&
                         (mark_count != CW'(MARK_DEPTH));
  assign m_wdata.pos   = write_total;
  assign m_wdata.frame = frame_l;
  assign m_re          = (state == S_MREQ);
  // drain looks one past the oldest mark, read looks at the oldest
  assign m_raddr       = (cmd == CMD_DRAIN) ? tail_inc : mark_tail;

  sfdm_mark_ram #(
    .MARK_DEPTH (MARK_DEPTH)
  ) u_mram (
    .clk   (clk),
    .we    (m_we),
    .waddr (mark_head),
    .wdata (m_wdata),
    .re    (m_re),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      write_total <= '0;
      read_total  <= '0;
      wr_addr     <= '0;
      rd_addr     <= '0;
      mark_head   <= '0;
      mark_tail   <= '0;
      mark_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd      <= cmd_t'(command);
            sample_l <= sample_in;
            frame_l  <= frame_index;
            want     <= (max_count > COUNT_W'(MAX_READ)) ? LW'(MAX_READ)
                                                         : LW'(max_count);
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          disc     <= 1'b0;
          start    <= '0;
          status_r <= ST_DONE;
          unique case (cmd)
            CMD_WRITE: begin
              if (ures.below) begin
                wr_addr     <= wr_inc;
                write_total <= write_total + POS_W'(1);
              end else begin
                status_r <= ST_FULL;
              end
              state <= S_RESP;
            end
            CMD_MARK: begin
              if (m_we) begin
                mark_head  <= head_inc;
                mark_count <= mark_count + CW'(1);
              end else begin
                status_r <= ST_FULL;
              end
              state <= S_RESP;
            end
            CMD_DRAIN: begin
              read_total <= write_total;
              rd_addr    <= wr_addr;
              state      <= S_DSCAN;
            end
            CMD_READ: begin
              if (ures.diff == '0 || want == '0) begin
                status_r <= ST_EMPTY;
                state    <= S_RESP;
              end else begin
                // fewer buffered than wanted: take them all
                remaining <= ures.below ? LW'(ures.diff) : want;
                state     <= S_RSCAN;
              end
            end
            default: state <= S_RESP;
          endcase
        end
        S_DSCAN: begin
          state <= (mark_count >= CW'(2)) ? S_MREQ : S_RESP;
        end
        S_RSCAN: begin
          state <= (mark_count != '0) ? S_MREQ : S_SREAD;
        end
        S_MREQ: begin
          state <= S_MTEST;
        end
        S_MTEST: begin
          if (cmd == CMD_DRAIN) begin
            if (ures.behind) begin
              mark_tail  <= tail_inc;
              mark_count <= mark_count - CW'(1);
              state      <= S_DSCAN;
            end else begin
              state <= S_RESP;
            end
          end else if (ures.behind) begin
            disc     <= 1'b1;
            mark_lag <= ures.diff;
            state    <= S_MFRAME;
          end else begin
            state <= S_LIMIT;
          end
        end
        S_MFRAME: begin
          start      <= m_rdata.frame + FRAME_W'(mark_lag);
          mark_tail  <= tail_inc;
          mark_count <= mark_count - CW'(1);
          state      <= S_RSCAN;
        end
        S_LIMIT: begin
          // stop short of the next pending mark
          if (ures.below) begin
            remaining <= LW'(ures.diff);
          end
          state <= S_SREAD;
        end
        S_SREAD: begin
          state <= S_SOUT;
        end
        S_SOUT: begin
          if (out_free) begin
            status        <= ST_DONE;
            sample_valid  <= 1'b1;
            sample_out    <= s_rdata;
            discontinuity <= disc;
            start_frame   <= start;
            last          <= (remaining == LW'(1));
            rd_addr       <= rd_inc;
            read_total    <= read_total + POS_W'(1);
            remaining     <= remaining - LW'(1);
            state         <= (remaining == LW'(1)) ? S_IDLE : S_SREAD;
          end
        end
        S_RESP: begin
          if (out_free) begin
            status        <= status_r;
            sample_valid  <= 1'b0;
            sample_out    <= '0;
            discontinuity <= 1'b0;
            start_frame   <= '0;
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/sfdm_pos_unit.sv]
// shared position unit: modular difference of two 32-bit positions and compares
// depends on sfdm_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfdm_pos_unit
  import sfdm_pkg::*;
(
  input  wire logic [POS_W-1:0] a,
  input  wire logic [POS_W-1:0] b,
  input  wire logic [POS_W-1:0] bound,
  output pos_res_t              res
);

  logic [POS_W-1:0] diff;

  assign diff = a - b;

  always_comb begin
    res.diff   = diff;
    // b at or behind a when the difference is below half the range
    res.behind = ~diff[POS_W-1];
    res.below  = diff < bound;
  end

endmodule

`default_nettype wire

[sv/sfdm_sample_ram.sv]
// sample store: one write port, one registered read port
// depends on sfdm_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfdm_sample_ram
  import sfdm_pkg::*;
#(
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
  localparam int AW = $clog2(SAMPLE_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [WORD_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [SAMPLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/sfdm_mark_ram.sv]
// mark queue storage: position and frame per slot, registered read
// depends on sfdm_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfdm_mark_ram
  import sfdm_pkg::*;
#(
  parameter int MARK_DEPTH = MARK_DEPTH_DEF,
  localparam int MAW = $clog2(MARK_DEPTH)
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [MAW-1:0] waddr,
  input  wire mark_t          wdata,
  input  wire logic           re,
  input  wire logic [MAW-1:0] raddr,
  output mark_t               rdata
);

  mark_t mem [MARK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/sfdm_checker.sv]
// port-level checks for the sample fifo with discontinuity marks, bound to the top level
// depends on sfdm_pkg and sample_fifo_with_discontinuity_marks
`timescale 1ns / 1ps
`default_nettype none

module sfdm_checker
  import sfdm_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [STAT_W-1:0]  status,
  input wire logic               sample_valid,
  input wire logic               discontinuity,
  input wire logic [FRAME_W-1:0] start_frame,
  input wire logic               last
);

  // an accepted word keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepted word");

  // a returned sample always reports success
  a_sample_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_valid |-> status == ST_DONE)
    else $error("sample word with failure status");

  // anything but a sample is a single-word answer
  a_single_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sample_valid |-> last && !discontinuity)
    else $error("non-sample word not final or flagged");

  // start frame is only meaningful with a discontinuity
  a_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !discontinuity |-> start_frame == '0)
    else $error("start frame without discontinuity");

endmodule

bind sample_fifo_with_discontinuity_marks sfdm_checker u_sfdm_checker (.*);

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// testbench for sample_fifo_with_discontinuity_marks: directed and random command words
// checked against a behavioral model of the sample fifo and its mark queue
// depends on sfdm_pkg and the block rtl

module testbench;
  import sfdm_pkg::*;

  localparam int SAMPLE_DEPTH  = SAMPLE_DEPTH_DEF;
  localparam int MARK_DEPTH    = MARK_DEPTH_DEF;
  localparam int MAX_READ      = MAX_READ_DEF;
  localparam int MARK_CW       = $clog2(MARK_DEPTH) + 1;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int PRINT_LIMIT   = 50;

  typedef enum {READY_ALWAYS, READY_RUNS, READY_RANDOM} ready_mode_t;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic               sample_valid;
    logic [WORD_W-1:0]  sample;
    logic               disc;
    logic [FRAME_W-1:0] start;
    logic               last;
  } fifo_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   command = CMD_WRITE;
  logic [WORD_W-1:0]  sample_in = '0;
  logic [FRAME_W-1:0] frame_index = '0;
  logic [COUNT_W-1:0] max_count = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [STAT_W-1:0]  status;
  logic               sample_valid;
  logic [WORD_W-1:0]  sample_out;
  logic               discontinuity;
  logic [FRAME_W-1:0] start_frame;
  logic               last;

  // model state
  logic [WORD_W-1:0]  store_mem [SAMPLE_DEPTH];
  logic [POS_W-1:0]   wr_total = '0;
  logic [POS_W-1:0]   rd_total = '0;
  logic [POS_W-1:0]   mark_pos_mem [MARK_DEPTH];
  logic [FRAME_W-1:0] mark_frame_mem [MARK_DEPTH];
  logic [MARK_CW-1:0] mark_head = '0;
  logic [MARK_CW-1:0] mark_tail = '0;
  fifo_result_t      awaited_words [$];

  int          error_count = 0;
  int          quiet_cycles = 0;
  bit          sender_gaps = 1'b0;
  bit          offering = 1'b0;
  int          burst_left = 0;
  ready_mode_t stall_mode = READY_ALWAYS;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          run_left = 0;
  bit          run_stalled = 1'b0;

  always #5 clk = ~clk;

  sample_fifo_with_discontinuity_marks #(
    .SAMPLE_DEPTH(SAMPLE_DEPTH),
    .MARK_DEPTH  (MARK_DEPTH),
    .MAX_READ    (MAX_READ)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .sample_in    (sample_in),
    .frame_index  (frame_index),
    .max_count    (max_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .sample_valid (sample_valid),
    .sample_out   (sample_out),
    .discontinuity(discontinuity),
    .start_frame  (start_frame),
    .last         (last)
  );

  function automatic logic [MARK_CW-1:0] marks_queued();
    return mark_head - mark_tail;
  endfunction

  function automatic logic [MARK_CW-2:0] slot_of(input logic [MARK_CW-1:0] ctr);
    return ctr[MARK_CW-2:0];
  endfunction

  // modular compare: the mark lies at or behind the read position
  function automatic logic mark_reached(input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] lag;
    lag = rd_total - pos;
    return !lag[POS_W-1];
  endfunction

  task automatic fifo_command_outcome(input cmd_t c, input logic [WORD_W-1:0] smp,
                                      input logic [FRAME_W-1:0] frm,
                                      input logic [COUNT_W-1:0] cnt);
    fifo_result_t       r;
    logic [POS_W-1:0]   take;
    logic [POS_W-1:0]   readable;
    logic [POS_W-1:0]   ahead;
    logic [POS_W-1:0]   lag;
    logic [FRAME_W-1:0] first_frame;
    logic               hit;
    r = '{status: ST_DONE, sample_valid: 1'b0, sample: '0, disc: 1'b0, start: '0,
          last: 1'b1};
    case (c)
      CMD_WRITE: begin
        if (wr_total - rd_total >= SAMPLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          store_mem[wr_total % SAMPLE_DEPTH] = smp;
          wr_total++;
        end
        awaited_words.push_back(r);
      end
      CMD_MARK: begin
        if (marks_queued() >= MARK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          mark_pos_mem[slot_of(mark_head)] = wr_total;
          mark_frame_mem[slot_of(mark_head)] = frm;
          mark_head++;
        end
        awaited_words.push_back(r);
      end
      CMD_DRAIN: begin
        rd_total = wr_total;
        // keep only the newest mark behind the read position
        while (marks_queued() >= 2 && mark_reached(mark_pos_mem[slot_of(mark_tail + 1'b1)]))
          mark_tail++;
        awaited_words.push_back(r);
      end
      default: begin
        take = (cnt > MAX_READ) ? MAX_READ : cnt;
        readable = wr_total - rd_total;
        if (readable == 0 || take == 0) begin
          r.status = ST_EMPTY;
          awaited_words.push_back(r);
        end else begin
          hit = 1'b0;
          first_frame = '0;
          while (marks_queued() > 0 && mark_reached(mark_pos_mem[slot_of(mark_tail)])) begin
            lag = rd_total - mark_pos_mem[slot_of(mark_tail)];
            hit = 1'b1;
            first_frame = mark_frame_mem[slot_of(mark_tail)] + FRAME_W'(lag);
            mark_tail++;
          end
          if (readable < take) take = readable;
          // a read never crosses the next pending mark
          if (marks_queued() > 0) begin
            ahead = mark_pos_mem[slot_of(mark_tail)] - rd_total;
            if (ahead < take) take = ahead;
          end
          for (int k = 0; k < take; k++) begin
            r.sample_valid = 1'b1;
            r.sample = store_mem[rd_total % SAMPLE_DEPTH];
            r.disc = hit;
            r.start = first_frame;
            r.last = (k == take - 1);
            rd_total++;
            awaited_words.push_back(r);
          end
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("%0t ns: %s got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic send_word(input cmd_t c, input logic [WORD_W-1:0] smp,
                           input logic [FRAME_W-1:0] frm, input logic [COUNT_W-1:0] cnt);
    in_valid <= 1'b1;
    command <= c;
    sample_in <= smp;
    frame_index <= frm;
    max_count <= cnt;
    offering = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fifo_command_outcome(c, smp, frm, cnt);
    if (sender_gaps) begin
      if (burst_left == 0) burst_left = $urandom_range(1, 16);
      burst_left--;
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        offering = 1'b0;
        // mostly short gaps, now and then longer than a full read
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 160)) @(posedge clk);
        else repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_word();
    int roll;
    logic [COUNT_W-1:0] cnt;
    roll = $urandom_range(0, 99);
    cnt = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(0, 127))
                                      : COUNT_W'($urandom_range(1, MAX_READ));
    if (roll < 45)
      send_word(CMD_WRITE, $urandom, {$urandom, $urandom}, cnt);
    else if (roll < 57)
      send_word(CMD_MARK, $urandom, {$urandom, $urandom}, cnt);
    else if (roll < 94)
      send_word(CMD_READ, $urandom, {$urandom, $urandom}, cnt);
    else
      send_word(CMD_DRAIN, $urandom, {$urandom, $urandom}, cnt);
  endtask

  task automatic test_commands_directed();
    sender_gaps = 1'b1;
    stall_mode = READY_RUNS;
    send_word(CMD_READ, '0, '0, 7'd64);
    send_word(CMD_WRITE, 32'h0000_0000, '0, '0);
    send_word(CMD_WRITE, 32'hFFFF_FFFF, '1, '1);
    send_word(CMD_WRITE, 32'h5555_AAAA, '0, '0);
    send_word(CMD_WRITE, 32'hAAAA_5555, '0, '0);
    send_word(CMD_READ, '0, '0, 7'd0);
    send_word(CMD_MARK, '0, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    send_word(CMD_WRITE, 32'h0000_0001, '0, '0);
    send_word(CMD_WRITE, 32'h8000_0000, '0, '0);
    // saturated count, stops short of the pending mark
    send_word(CMD_READ, '0, '0, 7'd127);
    send_word(CMD_READ, '0, '0, 7'd65);
    send_word(CMD_MARK, '0, 64'hFFFF_FFFF_FFFF_FFFD, '0);
    repeat (3) send_word(CMD_WRITE, $urandom, '0, '0);
    send_word(CMD_DRAIN, '0, '0, '0);
    send_word(CMD_WRITE, 32'h1234_5678, '0, '0);
    // start frame wraps past 2^64 after the drain skipped three samples
    send_word(CMD_READ, '0, '0, 7'd1);
    send_word(CMD_MARK, '0, 64'h0, '0);
    send_word(CMD_MARK, '0, 64'h1, '0);
    send_word(CMD_WRITE, 32'hCAFE_0001, '0, '0);
    send_word(CMD_DRAIN, '0, '0, '0);
    send_word(CMD_WRITE, 32'hCAFE_0002, '0, '0);
    send_word(CMD_READ, '0, '0, 7'd64);
    send_word(CMD_READ, '0, '0, 7'd64);
  endtask

  task automatic test_mark_queue_full();
    sender_gaps = 1'b1;
    stall_mode = READY_RUNS;
    for (int k = 0; k < MARK_DEPTH + 2; k++) begin
      send_word(CMD_MARK, $urandom, {$urandom, $urandom}, '0);
      if (k % 2 == 1) send_word(CMD_WRITE, $urandom, '0, '0);
    end
    while (wr_total != rd_total)
      send_word(CMD_READ, '0, '0, COUNT_W'($urandom_range(1, MAX_READ)));
    // a full queue of stale marks at one position, then a drain that drops all but one
    for (int k = 0; k < MARK_DEPTH + 1; k++)
      send_word(CMD_MARK, '0, {$urandom, $urandom}, '0);
    repeat (2) send_word(CMD_WRITE, $urandom, '0, '0);
    send_word(CMD_DRAIN, '0, '0, '0);
    send_word(CMD_WRITE, $urandom, '0, '0);
    send_word(CMD_READ, '0, '0, 7'd64);
  endtask

  task automatic test_backpressure();
    sender_gaps = 1'b0;
    stall_mode = READY_ALWAYS;
    hold_requests++;
    for (int k = 0; k < 40; k++) send_word(CMD_WRITE, $urandom, '0, '0);
    send_word(CMD_MARK, '0, {$urandom, $urandom}, '0);
    repeat (4) send_word(CMD_READ, '0, '0, 7'd64);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int words, input bit gaps, input ready_mode_t mode);
    int sent;
    int burst;
    sender_gaps = gaps;
    stall_mode = mode;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(0, 19) == 0) begin
        burst = $urandom_range(10, 40);
        repeat (burst) send_word(CMD_WRITE, $urandom, {$urandom, $urandom}, '0);
        sent += burst;
      end else begin
        send_random_word();
        sent++;
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    fifo_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_words.size() == 0) begin
        report_mismatch("word with none awaited, sample", sample_out, '0);
      end else begin
        want = awaited_words.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (sample_valid !== want.sample_valid)
          report_mismatch("sample_valid", sample_valid, want.sample_valid);
        if (sample_out !== want.sample) report_mismatch("sample_out", sample_out, want.sample);
        if (discontinuity !== want.disc)
          report_mismatch("discontinuity", discontinuity, want.disc);
        if (start_frame !== want.start)
          report_mismatch("start_frame", start_frame, want.start);
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
    end
  end

  // receiver stall pattern, plus long hold-offs on request
  always @(posedge clk) begin
    logic next_stall;
    next_stall = 1'b0;
    if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      next_stall = 1'b1;
    end else begin
      case (stall_mode)
        READY_RUNS: begin
          if (run_left == 0) begin
            run_stalled = !run_stalled;
            run_left = run_stalled ? $urandom_range(1, 6) : $urandom_range(1, 10);
          end
          run_left--;
          next_stall = run_stalled;
        end
        READY_RANDOM: next_stall = ($urandom_range(0, 2) == 0);
        default: next_stall = 1'b0;
      endcase
    end
    out_stall <= rst ? 1'b0 : next_stall;
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_commands_directed();
    wait_drained();
    test_mark_queue_full();
    wait_drained();
    test_backpressure();
    test_random_traffic(30, 1'b1, READY_RUNS);
    wait_drained();
    test_random_traffic(30, 1'b0, READY_ALWAYS);
    wait_drained();
    test_random_traffic(30, 1'b1, READY_RANDOM);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && awaited_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
